// ===== rtl/core/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit partition allocator: request
// and response payloads, request kinds, status codes and the control bundle
// between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

	localparam int MAX_PARTITIONS = 128;
	localparam int ADDR_BITS      = 16;
	localparam int IDX_W          = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_FREE  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOFIT    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		kind_t                kind;
		logic [ADDR_BITS-1:0] start_address;
		logic [ADDR_BITS-1:0] request_size;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [ADDR_BITS-1:0] granted_address;
	} rsp_t;

	// One table entry as stored in the partition memory
	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] size;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic start;   // load a new request, rewind the scan
		logic scan;    // walk the table
		logic finish;  // commit table update and load the response
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_done;  // match seen, table exhausted, or no scan needed
		logic out_free;   // response register can take a result this cycle
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Request sequencer: accepts a request, runs the table scan, then commits the
// result once the response register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ctrl
	import ffpa_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   req_valid,
	output logic  req_stall,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Take a request only while idle
	assign req_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ffpa_dp.sv =====
// ----------------------------------------------------------------------------
// ffpa_dp
// Allocator datapath: request register, partition memory with registered
// read, used-mark flops, scan counter, match logic and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_dp
	import ffpa_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t st,
	output logic  rsp_valid,
	input  wire   rsp_stall,
	output rsp_t  rsp
);

	entry_t mem [MAX_PARTITIONS];

	req_t                req_q;
	logic [CNT_W-1:0]    count_q;
	logic [MAX_PARTITIONS-1:0] used_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	entry_t              rd_data_s1;
	logic                found_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [ADDR_BITS-1:0] hit_start_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic scan_kind;
	logic match_s1;
	logic issue;
	logic exhausted;
	logic table_full;
	logic add_ok;

	assign scan_kind  = (req_q.kind == KIND_ALLOC) || (req_q.kind == KIND_FREE);
	assign table_full = (count_q == CNT_W'(MAX_PARTITIONS));
	assign add_ok     = cmd.finish && (req_q.kind == KIND_ADD) && !table_full;

	// Compare the entry read last cycle against the request
	always_comb begin
		match_s1 = 1'b0;
		if (rd_vld_s1) begin
			if (req_q.kind == KIND_ALLOC) begin
				match_s1 = !used_q[rd_idx_s1] && (rd_data_s1.size >= req_q.request_size);
			end else begin
				match_s1 = (rd_data_s1.start == req_q.start_address);
			end
		end
	end

	assign exhausted    = (scan_idx_q == count_q) && !rd_vld_s1;
	assign issue        = cmd.scan && scan_kind && !match_s1 && (scan_idx_q < count_q);
	assign st.scan_done = !scan_kind || match_s1 || exhausted;
	assign st.out_free  = !rsp_valid_q || !rsp_stall;

	// Partition memory: write on add, registered read during the scan
	always_ff @(posedge clk) begin
		if (add_ok) begin
			mem[count_q[IDX_W-1:0]] <= '{start: req_q.start_address,
			                            size:  req_q.request_size};
		end
		if (issue) begin
			rd_data_s1 <= mem[scan_idx_q[IDX_W-1:0]];
		end
	end

	// Hold the request and the hit entry
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
		end
		if (issue) begin
			rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		end
		if (cmd.scan && match_s1) begin
			hit_idx_q   <= rd_idx_s1;
			hit_start_q <= rd_data_s1.start;
		end
	end

	// Scan control: counter, read pipeline valid, found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.start) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (cmd.scan && match_s1) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Commit the table update: count and used marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q  <= '0;
		end else if (cmd.finish) begin
			if (add_ok) begin
				count_q                     <= count_q + 1'b1;
				used_q[count_q[IDX_W-1:0]]  <= 1'b0;
			end
			if (found_q && (req_q.kind == KIND_ALLOC)) begin
				used_q[hit_idx_q] <= 1'b1;
			end
			if (found_q && (req_q.kind == KIND_FREE)) begin
				used_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// Response valid: set on commit, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.granted_address <= '0;
			unique case (req_q.kind)
				KIND_ADD: begin
					rsp_q.status <= table_full ? ST_FULL : ST_OK;
				end
				KIND_ALLOC: begin
					rsp_q.status <= found_q ? ST_OK : ST_NOFIT;
					if (found_q) begin
						rsp_q.granted_address <= hit_start_q;
					end
				end
				KIND_FREE: begin
					rsp_q.status <= found_q ? ST_OK : ST_NOTFOUND;
				end
				default: begin
					rsp_q.status <= ST_OK;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_partition_allocator
// Table of fixed memory partitions serving add, first-fit allocate and
// free-by-start requests, one response per request.
//
//   channel  payload  handshake             direction
//   req      req_t    req_valid/req_stall   into the block
//   rsp      rsp_t    rsp_valid/rsp_stall   out of the block
//
// Add and unknown requests need no scan and go straight on to commit.
// Allocate and free scan the table one entry per cycle through the
// partition memory read port, stopping at the first match.
// A new request is taken once the previous one is committed, while its
// response may still wait in the response register.
// Reset empties the table and clears all used marks; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_partition_allocator
	import ffpa_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t st;

	ffpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	ffpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit partition allocator. Directed
// requests cover an empty table, zero and maximal sizes, duplicate
// starts, repeated frees and unknown kinds. Random traffic then fills the
// table and mixes allocations and frees against known starts. A scoreboard
// predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import ffpa_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int SETTLE_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	first_fit_partition_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the partition table
	logic [ADDR_BITS-1:0] tbl_start [MAX_PARTITIONS];
	logic [ADDR_BITS-1:0] tbl_size  [MAX_PARTITIONS];
	bit                   tbl_used  [MAX_PARTITIONS];
	int                   tbl_count = 0;

	rsp_t                 predicted_rsp_q[$];
	req_t                 pending_q[$];
	bit                   drain_q[$];
	logic [ADDR_BITS-1:0] known_starts[$];

	int accepted_count;
	int returned_count = 0;
	int gap_left;
	int burst_left;
	int stall_mode;
	int stall_phase;
	int stall_run;
	int errors = 0;

	// Apply one request to the shadow table and return its response
	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		bit   hit;
		o.status = ST_OK;
		o.granted_address = '0;
		hit = 1'b0;
		case (r.kind)
			KIND_ADD: begin
				if (tbl_count >= MAX_PARTITIONS) begin
					o.status = ST_FULL;
				end else begin
					tbl_start[tbl_count] = r.start_address;
					tbl_size[tbl_count] = r.request_size;
					tbl_used[tbl_count] = 1'b0;
					tbl_count++;
				end
			end
			KIND_ALLOC: begin
				for (int i = 0; i < tbl_count && !hit; i++) begin
					if (!tbl_used[i] && tbl_size[i] >= r.request_size) begin
						tbl_used[i] = 1'b1;
						o.granted_address = tbl_start[i];
						hit = 1'b1;
					end
				end
				if (!hit) o.status = ST_NOFIT;
			end
			KIND_FREE: begin
				for (int i = 0; i < tbl_count && !hit; i++) begin
					if (tbl_start[i] == r.start_address) begin
						tbl_used[i] = 1'b0;
						hit = 1'b1;
					end
				end
				if (!hit) o.status = ST_NOTFOUND;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// Append one request; drain holds it back until all responses are in
	function automatic void queue_request(kind_t k, logic [ADDR_BITS-1:0] a,
			logic [ADDR_BITS-1:0] s, bit drain);
		req_t r;
		r.kind = k;
		r.start_address = a;
		r.request_size = s;
		pending_q.push_back(r);
		drain_q.push_back(drain);
		if (k == KIND_ADD && known_starts.size() < MAX_PARTITIONS)
			known_starts.push_back(a);
	endfunction

	function automatic logic [ADDR_BITS-1:0] pick_size();
		case ($urandom_range(0, 4))
			0: return ADDR_BITS'($urandom);
			1: return ADDR_BITS'($urandom_range(0, 255));
			2: return ADDR_BITS'($urandom_range(0, 4095));
			3: return ($urandom_range(0, 1) != 0) ? {ADDR_BITS{1'b1}} : '0;
			default: return ADDR_BITS'($urandom_range(4096, 65535));
		endcase
	endfunction

	// Favor starts already in the table so frees hit and duplicates occur
	function automatic logic [ADDR_BITS-1:0] pick_start();
		if (known_starts.size() > 0 && $urandom_range(0, 9) < 7)
			return known_starts[$urandom_range(0, known_starts.size() - 1)];
		if ($urandom_range(0, 1) == 0)
			return ADDR_BITS'($urandom_range(0, 15) << 12);
		return ADDR_BITS'($urandom);
	endfunction

	// Driver: record each transfer, then offer the next request in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			accepted_count = 0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (req_valid && !req_stall) begin
				predicted_rsp_q.push_back(serve_request(req));
				accepted_count++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_q.size() == 0 ||
						(drain_q[0] && returned_count != accepted_count)) begin
					req_valid <= 1'b0;
				end else begin
					req <= pending_q.pop_front();
					void'(drain_q.pop_front());
					req_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// Response stall: switch between free-running, random, periodic and long runs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode = 0;
			stall_phase = 0;
			stall_run = 0;
		end else begin
			if (stall_phase == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_phase = $urandom_range(50, 400);
			end else begin
				stall_phase--;
			end
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 1) == 0);
				2: rsp_stall <= (stall_phase % 3 == 0);
				default: begin
					if (stall_run > 0) begin
						stall_run--;
					end else begin
						stall_run = $urandom_range(1, 20);
						rsp_stall <= !rsp_stall;
					end
				end
			endcase
		end
	end

	// Monitor: check each response transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			returned_count <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			returned_count <= returned_count + 1;
			if (predicted_rsp_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response: status %0d address %h",
						rsp.status, rsp.granted_address);
			end else begin
				want = predicted_rsp_q.pop_front();
				if (rsp.status !== want.status ||
						rsp.granted_address !== want.granted_address) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: status exp %0d got %0d, address exp %h got %h",
							want.status, rsp.status, want.granted_address,
							rsp.granted_address);
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int  roll;
		bit  full;
		bit  drain;

		// Empty table: nothing to free or allocate
		queue_request(KIND_FREE, 16'h1234, 16'h0000, 1'b0);
		queue_request(KIND_ALLOC, 16'h0000, 16'h0000, 1'b0);
		queue_request(KIND_NONE, '1, '1, 1'b0);
		// Zero-size, maximal and duplicate-start partitions
		queue_request(KIND_ADD, 16'h0000, 16'h0000, 1'b0);
		queue_request(KIND_ADD, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_request(KIND_ADD, 16'h1000, 16'h0100, 1'b0);
		queue_request(KIND_ADD, 16'h1000, 16'h0800, 1'b0);
		// Zero request takes the first free entry, then exact and oversize fits
		queue_request(KIND_ALLOC, 16'hFFFF, 16'h0000, 1'b0);
		queue_request(KIND_ALLOC, 16'h0000, 16'hFFFF, 1'b0);
		queue_request(KIND_ALLOC, 16'h0000, 16'h0100, 1'b0);
		queue_request(KIND_ALLOC, 16'h0000, 16'h0100, 1'b0);
		queue_request(KIND_ALLOC, 16'h0000, 16'h0001, 1'b0);
		// Free hits only the lowest entry with a duplicated start
		queue_request(KIND_FREE, 16'h1000, 16'hFFFF, 1'b0);
		queue_request(KIND_ALLOC, 16'h0000, 16'h0200, 1'b0);
		queue_request(KIND_ALLOC, 16'h0000, 16'h0100, 1'b0);
		// Free twice, then an unknown start
		queue_request(KIND_FREE, 16'h0000, 16'h0000, 1'b0);
		queue_request(KIND_FREE, 16'h0000, 16'h0000, 1'b0);
		queue_request(KIND_FREE, 16'h5555, 16'h0000, 1'b0);
		queue_request(KIND_NONE, '0, '0, 1'b0);
		queue_request(KIND_ALLOC, 16'h0000, 16'h0000, 1'b0);

		// Random traffic: add-heavy until the table is full, then alloc and free
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			full = known_starts.size() >= MAX_PARTITIONS;
			drain = (n == 0) || ($urandom_range(0, 199) == 0);
			if (roll < (full ? 5 : 35))
				queue_request(KIND_ADD, pick_start(), pick_size(), drain);
			else if (roll < (full ? 52 : 68))
				queue_request(KIND_ALLOC, ADDR_BITS'($urandom), pick_size(), drain);
			else if (roll < 95)
				queue_request(KIND_FREE, pick_start(), ADDR_BITS'($urandom), drain);
			else
				queue_request(KIND_NONE, ADDR_BITS'($urandom), ADDR_BITS'($urandom), drain);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || req_valid || predicted_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0 && predicted_rsp_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#8_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
